// File: hw/rtl/slmi_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// servo linear move interpolator. No dependencies.
package slmi_pkg;

  localparam int CHANNELS  = 6;
  localparam int FRAC_BITS = 8;
  localparam int ANGLE_W   = 8;
  localparam int DUR_W     = 16;
  localparam int TICK_W    = 13;
  localparam int TICK_MS   = 10;

  // duration / 10 as (duration * 52429) >> 19, exact over 16 bits
  localparam int TICK_RECIP = 52429;
  localparam int TICK_SHIFT = 19;

  localparam int ACC_W      = ANGLE_W + FRAC_BITS;
  localparam int STEP_W     = ACC_W + 1;
  // magnitude * (10 << FRAC_BITS) needs four bits above the accumulator
  localparam int NUM_W      = ANGLE_W + FRAC_BITS + 4;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int IN_DATA_W  = DUR_W + ANGLE_W * CHANNELS;
  localparam int OUT_DATA_W = ANGLE_W * CHANNELS;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic            load;
    logic            prep;
    logic            tick;
    logic            div_start;
    logic            div_commit;
    logic            emit;
    logic [CH_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_long;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hw/rtl/servo_linear_move_interpolator.sv
// Top level of the six-channel servo linear move interpolator.
// Depends on slmi_pkg, slmi_ctrl and slmi_datapath.
//
// One input word gives one output word. A tick word, and a start word of
// 10 ms or less, passes from acceptance through PREP and EMIT to its result
// being loaded. A longer start word also runs the channels one after another
// through a single restoring divider, one quotient bit per cycle, which
// computes each channel's step, while the tick count comes from a reciprocal
// multiply at start. Items are handled one at a time; the next word is
// accepted while the previous result still waits in the output register.
// channel_enable is written through the cfg port and resets to all channels
// enabled.
module servo_linear_move_interpolator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // duration_ms, target_0 .. target_5
  input  logic [slmi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // angle_0 .. angle_5
  output logic [slmi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // moving
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [slmi_pkg::CHANNELS-1:0]   cfg_data_i
);

  slmi_pkg::dp_cmd_t    cmd;
  slmi_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  slmi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  slmi_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result overwrites a pending word");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while one is in work");

  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_commit |-> status.div_done)
    else $error("quotient committed before divider finished");
`endif

endmodule

// File: hw/rtl/slmi_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on slmi_pkg for widths.
module slmi_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [slmi_pkg::NUM_W-1:0] num_i,
  input  logic [slmi_pkg::DUR_W-1:0] den_i,
  output logic [slmi_pkg::NUM_W-1:0] quo_o,
  output logic                       done_o
);

  logic [slmi_pkg::DUR_W-1:0]     rem_q, den_q;
  logic [slmi_pkg::NUM_W-1:0]     quo_q;
  logic [slmi_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;

  logic [slmi_pkg::DUR_W:0]   trial, diff;
  logic                       fits;
  logic [slmi_pkg::DUR_W-1:0] rem_d;

  assign trial = {rem_q, quo_q[slmi_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? diff[slmi_pkg::DUR_W-1:0] : trial[slmi_pkg::DUR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[slmi_pkg::NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= slmi_pkg::DIV_CNT_W'(slmi_pkg::NUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/slmi_datapath.sv
// Channel state, step computation, tick update and output register.
// Depends on slmi_pkg and slmi_divider.
module slmi_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slmi_pkg::dp_cmd_t               cmd_i,
  output slmi_pkg::dp_status_t            status_o,
  input  logic [slmi_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            in_user_i,
  input  logic                            cfg_valid_i,
  input  logic [slmi_pkg::CHANNELS-1:0]   cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [slmi_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_user_o
);

  localparam int CH  = slmi_pkg::CHANNELS;
  localparam int FB  = slmi_pkg::FRAC_BITS;
  localparam int AW  = slmi_pkg::ANGLE_W;
  localparam int ACW = slmi_pkg::ACC_W;
  localparam int SW  = slmi_pkg::STEP_W;
  localparam int NW  = slmi_pkg::NUM_W;
  localparam int DW  = slmi_pkg::DUR_W;

  logic [CH-1:0]               en_q;
  logic                        in_cmd_q;
  logic [DW-1:0]               dur_q;
  logic [AW-1:0]               tgt_q  [CH];
  logic [ACW-1:0]              acc_q  [CH];
  logic [SW-1:0]               step_q [CH];
  logic [AW-1:0]               goal_q [CH];
  logic [slmi_pkg::TICK_W-1:0] ticks_q;
  logic                        out_valid_q, out_user_q;
  logic [slmi_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                        is_long, sel_neg, ticks_nz, last_tick;
  logic [slmi_pkg::CH_W-1:0]   sel;
  logic [AW-1:0]               sel_cur, sel_mag;
  logic [NW-1:0]               mag_ext, div_num, quo;
  logic [DW-1:0]               div_den;
  logic [SW-1:0]               q_ext, step_val;
  logic [slmi_pkg::TICK_W-1:0] ticks_dec;
  logic [31:0]                 tick_prod;
  logic                        div_done;
  logic [slmi_pkg::OUT_DATA_W-1:0] angles;

  assign is_long    = dur_q > DW'(slmi_pkg::TICK_MS);
  assign sel        = cmd_i.idx;
  assign sel_cur    = acc_q[sel][ACW-1:FB];
  assign sel_neg    = goal_q[sel] < sel_cur;
  assign sel_mag    = sel_neg ? (sel_cur - goal_q[sel]) : (goal_q[sel] - sel_cur);
  assign mag_ext    = NW'(sel_mag);
  // magnitude * 10 * 2^FRAC_BITS
  assign div_num    = (mag_ext << (FB + 3)) + (mag_ext << (FB + 1));
  assign div_den    = dur_q;
  assign q_ext      = {1'b0, quo[ACW-1:0]};
  assign step_val   = sel_neg ? (SW'(0) - q_ext) : q_ext;
  assign ticks_nz   = ticks_q != '0;
  assign ticks_dec  = ticks_q - 1'b1;
  assign last_tick  = ticks_dec == '0;
  assign tick_prod  = 32'(dur_q) * 32'(slmi_pkg::TICK_RECIP);

  slmi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .done_o (div_done)
  );

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      angles[c*AW +: AW] = acc_q[c][ACW-1:FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_cmd_q <= in_user_i;
      dur_q    <= in_data_i[DW-1:0];
      for (int c = 0; c < CH; c++) begin
        tgt_q[c] <= in_data_i[DW + c*AW +: AW];
      end
    end
    if (cmd_i.emit) begin
      out_data_q <= angles;
      out_user_q <= ticks_nz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '1;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CH; c++) begin
        acc_q[c]  <= '0;
        step_q[c] <= '0;
        goal_q[c] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      if (cmd_i.prep) begin
        ticks_q <= is_long ? tick_prod[slmi_pkg::TICK_SHIFT +: slmi_pkg::TICK_W] : '0;
        for (int c = 0; c < CH; c++) begin
          step_q[c] <= '0;
          if (en_q[c]) begin
            goal_q[c] <= tgt_q[c];
            acc_q[c]  <= is_long ? {acc_q[c][ACW-1:FB], {FB{1'b0}}} : {tgt_q[c], {FB{1'b0}}};
          end else begin
            goal_q[c] <= acc_q[c][ACW-1:FB];
          end
        end
      end
      if (cmd_i.tick && ticks_nz) begin
        ticks_q <= ticks_dec;
        for (int c = 0; c < CH; c++) begin
          if (en_q[c]) begin
            acc_q[c] <= last_tick ? {goal_q[c], {FB{1'b0}}} : (acc_q[c] + step_q[c][ACW-1:0]);
          end
        end
      end
      if (cmd_i.div_commit) begin
        step_q[sel] <= step_val;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.is_tick  = in_cmd_q == slmi_pkg::CMD_TICK;
  assign status_o.is_long  = is_long;
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// File: hw/rtl/slmi_ctrl.sv
// Sequencer: accepts a word, runs the start or tick update, steps the
// shared divider over the channels for a long start word, then emits a word.
// Depends on slmi_pkg.
module slmi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  slmi_pkg::dp_status_t status_i,
  output slmi_pkg::dp_cmd_t    cmd_o
);

  slmi_pkg::state_e             state_q, state_d;
  logic [slmi_pkg::CH_W-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slmi_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      slmi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = slmi_pkg::ST_PREP;
        end
      end
      slmi_pkg::ST_PREP: begin
        if (status_i.is_tick) begin
          cmd_o.tick = 1'b1;
          state_d    = slmi_pkg::ST_EMIT;
        end else begin
          cmd_o.prep = 1'b1;
          if (status_i.is_long) begin
            cnt_d   = '0;
            state_d = slmi_pkg::ST_DIV_GO;
          end else begin
            state_d = slmi_pkg::ST_EMIT;
          end
        end
      end
      slmi_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = slmi_pkg::ST_DIV_WAIT;
      end
      slmi_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          if (cnt_q == slmi_pkg::CH_W'(slmi_pkg::CHANNELS - 1)) begin
            state_d = slmi_pkg::ST_EMIT;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = slmi_pkg::ST_DIV_GO;
          end
        end
      end
      slmi_pkg::ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = slmi_pkg::ST_IDLE;
        end
      end
      default: state_d = slmi_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: tb/sv/servo_linear_move_interpolator_tb.sv
// Self-checking testbench for servo_linear_move_interpolator: a directed
// table, then random move/tick sequences, checked against a built-in
// predictor. Depends on slmi_pkg and the interpolator RTL.
module servo_linear_move_interpolator_tb;

  localparam int WORD_TARGET = 1950;
  localparam int CALM_WORDS  = 200;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SCRIPT_LEN  = 26;

  typedef struct packed {
    logic                                               cmd;
    logic [slmi_pkg::DUR_W-1:0]                         dur;
    logic [slmi_pkg::CHANNELS-1:0][slmi_pkg::ANGLE_W-1:0] targets;
  } move_word_t;

  typedef struct packed {
    logic [slmi_pkg::CHANNELS-1:0][slmi_pkg::ANGLE_W-1:0] angle;
    logic                                               moving;
  } pose_t;

  typedef enum logic {ROW_WORD, ROW_ENABLE} row_kind_e;

  typedef struct packed {
    row_kind_e                                          kind;
    logic                                               cmd;
    logic [slmi_pkg::DUR_W-1:0]                         dur;
    logic [slmi_pkg::CHANNELS-1:0][slmi_pkg::ANGLE_W-1:0] targets;
    logic [slmi_pkg::CHANNELS-1:0]                      enable;
    logic                                               typed;
    pose_t                                              pose;
  } script_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // duration_ms, target_0 .. target_5
  logic [slmi_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  // command
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // angle_0 .. angle_5
  logic [slmi_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // moving
  logic                            m_axis_tuser;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [slmi_pkg::CHANNELS-1:0]   cfg_data_i;

  servo_linear_move_interpolator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic        [slmi_pkg::ACC_W-1:0]   acc_q   [slmi_pkg::CHANNELS];
  logic signed [slmi_pkg::STEP_W-1:0]  step_q  [slmi_pkg::CHANNELS];
  logic        [slmi_pkg::ANGLE_W-1:0] goal_q  [slmi_pkg::CHANNELS];
  logic        [slmi_pkg::TICK_W-1:0]  ticks_q;
  logic        [slmi_pkg::CHANNELS-1:0] enable_q;

  pose_t pose_q [$];
  int    fault_count = 0;
  int    words_sent  = 0;
  int    poses_seen  = 0;
  bit    calm        = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b1, '{{6{8'd0}}, 1'b0}},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd0,     {6{8'd180}}, 6'd0,  1'b1,
      '{{6{8'd180}}, 1'b0}},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd10,    {6{8'd0}},   6'd0,  1'b1, '{{6{8'd0}}, 1'b0}},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd10,    {6{8'd255}}, 6'd0,  1'b1,
      '{{6{8'd255}}, 1'b0}},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd65535,
      {8'd0, 8'd45, 8'd90, 8'd135, 8'd180, 8'd255},         6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd11,
      {8'd180, 8'd0, 8'd180, 8'd0, 8'd180, 8'd0},           6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'hFFFF,  {6{8'd255}}, 6'd0,  1'b0, '0},
    '{ROW_ENABLE, slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd5,     {6{8'd100}}, 6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd300,   {6{8'd10}},  6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_ENABLE, slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'h2A, 1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd40,
      {8'd170, 8'd3, 8'd170, 8'd3, 8'd170, 8'd3},           6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_ENABLE, slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'h15, 1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_ENABLE, slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'h3F, 1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_START, 16'd25,
      {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6},                 6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0},
    '{ROW_WORD,   slmi_pkg::CMD_TICK,  16'd0,     {6{8'd0}},   6'd0,  1'b0, '0}
  };

  function automatic void snap_to_goals();
    for (int c = 0; c < slmi_pkg::CHANNELS; c++)
      if (enable_q[c]) acc_q[c] = {goal_q[c], {slmi_pkg::FRAC_BITS{1'b0}}};
  endfunction

  function automatic pose_t servo_advance(input move_word_t w);
    pose_t p;
    int    cur;
    int    tgt;
    int    mag;
    int    quo;
    if (w.cmd == slmi_pkg::CMD_START) begin
      for (int c = 0; c < slmi_pkg::CHANNELS; c++) begin
        cur = int'(acc_q[c][slmi_pkg::ACC_W-1:slmi_pkg::FRAC_BITS]);
        tgt = int'(w.targets[c]);
        if (!enable_q[c]) begin
          step_q[c] = '0;
          goal_q[c] = slmi_pkg::ANGLE_W'(cur);
        end else begin
          goal_q[c] = slmi_pkg::ANGLE_W'(tgt);
          acc_q[c]  = slmi_pkg::ACC_W'(cur << slmi_pkg::FRAC_BITS);
          if (w.dur > slmi_pkg::TICK_MS) begin
            mag = (tgt < cur) ? cur - tgt : tgt - cur;
            quo = (mag * (slmi_pkg::TICK_MS << slmi_pkg::FRAC_BITS)) / int'(w.dur);
            step_q[c] = slmi_pkg::STEP_W'((tgt < cur) ? -quo : quo);
          end else begin
            step_q[c] = '0;
          end
        end
      end
      if (w.dur > slmi_pkg::TICK_MS) begin
        ticks_q = slmi_pkg::TICK_W'(w.dur / slmi_pkg::TICK_MS);
      end else begin
        ticks_q = '0;
        snap_to_goals();
      end
    end else if (ticks_q != 0) begin
      for (int c = 0; c < slmi_pkg::CHANNELS; c++)
        if (enable_q[c])
          acc_q[c] = slmi_pkg::ACC_W'(int'(acc_q[c]) + int'(step_q[c]));
      ticks_q--;
      if (ticks_q == 0) snap_to_goals();
    end
    for (int c = 0; c < slmi_pkg::CHANNELS; c++)
      p.angle[c] = acc_q[c][slmi_pkg::ACC_W-1:slmi_pkg::FRAC_BITS];
    p.moving = (ticks_q != 0);
    return p;
  endfunction

  function automatic logic [slmi_pkg::CHANNELS-1:0] pick_enable();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return slmi_pkg::CHANNELS'($urandom);
  endfunction

  task automatic note_mismatch(input string field, input int want_v, input int got_v);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
  endtask

  // leaves tvalid high so a following word goes out back to back
  task automatic send_word(input move_word_t w, input bit typed, input pose_t typed_pose);
    int    gap;
    pose_t p;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.targets, w.dur};
    s_axis_tuser  <= w.cmd;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    p = servo_advance(w);
    pose_q.push_back(typed ? typed_pose : p);
    words_sent++;
    if (words_sent >= WORD_TARGET - CALM_WORDS) calm = 1'b1;
  endtask

  // only while idle: drains every pending result first
  task automatic write_enable(input logic [slmi_pkg::CHANNELS-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    enable_q = value;
  endtask

  function automatic move_word_t random_tick();
    move_word_t w;
    w.cmd = slmi_pkg::CMD_TICK;
    w.dur = slmi_pkg::DUR_W'($urandom);
    for (int c = 0; c < slmi_pkg::CHANNELS; c++)
      w.targets[c] = slmi_pkg::ANGLE_W'($urandom);
    return w;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: check at mid-cycle, transfer at the next rising edge
  initial begin
    pose_t want;
    int    out_gap;
    bit    squeezed;
    out_gap  = 0;
    squeezed = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        poses_seen++;
        if (pose_q.size() == 0) begin
          note_mismatch("unexpected word", 0, 0);
        end else begin
          want = pose_q.pop_front();
          for (int c = 0; c < slmi_pkg::CHANNELS; c++)
            if (m_axis_tdata[c*slmi_pkg::ANGLE_W +: slmi_pkg::ANGLE_W] != want.angle[c])
              note_mismatch($sformatf("angle_%0d", c), int'(want.angle[c]),
                            int'(m_axis_tdata[c*slmi_pkg::ANGLE_W +: slmi_pkg::ANGLE_W]));
          if (m_axis_tuser != want.moving)
            note_mismatch("moving", int'(want.moving), int'(m_axis_tuser));
        end
      end
      @(posedge clk_i);
      // long hold-off: the block fills up and stalls its input
      if (!squeezed && poses_seen >= 400) begin
        out_gap  = 600;
        squeezed = 1'b1;
      end
      if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  initial begin
    move_word_t w;
    int         ticks;
    int         n_ticks;
    int         mid;
    int         r;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    enable_q      = '1;
    ticks_q       = '0;
    for (int c = 0; c < slmi_pkg::CHANNELS; c++) begin
      acc_q[c]  = '0;
      step_q[c] = '0;
      goal_q[c] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_ENABLE) begin
        write_enable(script[i].enable);
      end else begin
        w.cmd     = script[i].cmd;
        w.dur     = script[i].dur;
        w.targets = script[i].targets;
        send_word(w, script[i].typed, script[i].pose);
      end
    end

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 11) == 0) write_enable(pick_enable());
      w.cmd = slmi_pkg::CMD_START;
      r = $urandom_range(0, 99);
      if (r < 10)
        w.dur = slmi_pkg::DUR_W'($urandom_range(0, slmi_pkg::TICK_MS));
      else if (r < 85)
        w.dur = slmi_pkg::DUR_W'($urandom_range(slmi_pkg::TICK_MS + 1, 400));
      else if (r < 95)
        w.dur = slmi_pkg::DUR_W'($urandom_range(401, 3000));
      else
        w.dur = slmi_pkg::DUR_W'($urandom);
      for (int c = 0; c < slmi_pkg::CHANNELS; c++)
        w.targets[c] = ($urandom_range(0, 9) == 0)
                       ? slmi_pkg::ANGLE_W'($urandom_range(0, 255))
                       : slmi_pkg::ANGLE_W'($urandom_range(0, 180));
      send_word(w, 1'b0, '0);
      ticks = (w.dur > slmi_pkg::TICK_MS) ? w.dur / slmi_pkg::TICK_MS : 0;
      // for moves of up to 60 ticks, mostly run the move out (plus a few idle ticks), else cut it short
      if (ticks <= 60 && $urandom_range(0, 9) < 7) n_ticks = ticks + $urandom_range(0, 3);
      else n_ticks = $urandom_range(0, (ticks < 60) ? ticks : 60);
      mid = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_ticks) : -1;
      for (int i = 0; i < n_ticks; i++) begin
        if (i == mid) write_enable(pick_enable());
        send_word(random_tick(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fault_count == 0 && pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
